// ===== rtl/assert_macros.svh =====
// assert_macros.svh
// Concurrent assertion shorthands for the wipe key generator checkers.
// Depends on nothing; included by checker files only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VWKG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VWKG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/vwkg_pkg.sv =====
// vwkg_pkg.sv
// Shared widths, register codes, mode codes and beat types of the wipe key generator.
// Depends on nothing; used by every other file of the block but assert_macros.svh.
package vwkg_pkg;

	localparam int COORD_W         = 12;
	localparam int COORD_SPAN      = 1 << COORD_W;
	localparam int DIM_CFG_W       = 13;
	localparam int AMT_W           = 17;
	localparam int AMT_FRAC        = 16;
	localparam int MODE_W          = 2;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 17;
	localparam int MAX_DIM_DEFAULT = 4096;
	// circle test: (dx^2 + dy^2) * 4 * 2^32 against a^2 * (W^2 + H^2)
	localparam int LHS_SHIFT       = 2 * AMT_FRAC + 2;

	localparam logic [AMT_W-1:0] AMT_ONE = AMT_W'(1 << AMT_FRAC);

	localparam logic [MODE_W-1:0] MODE_IRIS_RECT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_IRIS_CIRCLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SPLIT4      = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AMOUNT = 2'd3;

	localparam logic [MODE_W-1:0]    MODE_RESET   = MODE_IRIS_RECT;
	localparam logic [DIM_CFG_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [AMT_W-1:0]     AMOUNT_RESET = '0;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} pix_in_t;

	typedef struct packed {
		logic               take_second;
		logic [COORD_W-1:0] source_x;
		logic [COORD_W-1:0] source_y;
	} pix_out_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

// ===== rtl/vwkg_circle_thr.sv =====
// vwkg_circle_thr.sv
// Iris circle threshold: (a^2 * (W^2 + H^2)) >> LHS_SHIFT over stages two to five.
// Depends on vwkg_pkg.
module vwkg_circle_thr #(
	parameter int MAX_DIM = vwkg_pkg::MAX_DIM_DEFAULT
) (
	input  logic                                  clk,
	input  vwkg_pkg::stage_en_t                   stage_en,
	input  logic [vwkg_pkg::AMT_W-1:0]            amount_sat,
	input  logic [$clog2(MAX_DIM+1)-1:0]          width_sat,
	input  logic [$clog2(MAX_DIM+1)-1:0]          height_sat,
	output logic [2*vwkg_pkg::AMT_W+2*$clog2(MAX_DIM+1)+1-vwkg_pkg::LHS_SHIFT-1:0] thr
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int SQ_W  = 2 * DIM_W;
	localparam int S_W   = SQ_W + 1;
	localparam int ASQ_W = 2 * vwkg_pkg::AMT_W;
	localparam int SPLIT = vwkg_pkg::AMT_W;
	localparam int HI_W  = ASQ_W - SPLIT;
	localparam int PL_W  = SPLIT + S_W;
	localparam int PH_W  = HI_W + S_W;
	localparam int RHS_W = ASQ_W + S_W;

	logic [ASQ_W-1:0] asq_s2, asq_s3;
	logic [SQ_W-1:0]  wsq_s2, hsq_s2;
	logic [S_W-1:0]   s_s3;
	logic [PL_W-1:0]  plo_s4;
	logic [PH_W-1:0]  phi_s4;
	logic [RHS_W-1:0] rhs_c;
	logic [RHS_W-vwkg_pkg::LHS_SHIFT-1:0] thr_s5;

	always_ff @(posedge clk) begin
		if (stage_en.s2) begin
			asq_s2 <= ASQ_W'(amount_sat) * ASQ_W'(amount_sat);
			wsq_s2 <= SQ_W'(width_sat) * SQ_W'(width_sat);
			hsq_s2 <= SQ_W'(height_sat) * SQ_W'(height_sat);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en.s3) begin
			s_s3   <= S_W'(wsq_s2) + S_W'(hsq_s2);
			asq_s3 <= asq_s2;
		end
	end

	// split the 34-bit square so each partial product stays under 32x32
	always_ff @(posedge clk) begin
		if (stage_en.s4) begin
			plo_s4 <= PL_W'(asq_s3[SPLIT-1:0]) * PL_W'(s_s3);
			phi_s4 <= PH_W'(asq_s3[ASQ_W-1:SPLIT]) * PH_W'(s_s3);
		end
	end

	assign rhs_c = (RHS_W'(phi_s4) << SPLIT) + RHS_W'(plo_s4);

	always_ff @(posedge clk) begin
		if (stage_en.s5) begin
			thr_s5 <= rhs_c[RHS_W-1:vwkg_pkg::LHS_SHIFT];
		end
	end

	assign thr = thr_s5;

endmodule

// ===== rtl/video_wipe_key_generator_unit.sv =====
// video_wipe_key_generator_unit.sv
// Top level of the wipe key generator: config registers, six-stage pixel pipeline.
// Depends on vwkg_pkg and vwkg_circle_thr.

// Wipe key generator. Give it one output pixel coordinate per beat on the pix channel and
// it returns one key beat: take_second tells the mixer to show the incoming source, and
// source_x/source_y give the coordinate of the outgoing source to fetch (the four way
// split pushes quadrants outward; the other wipes fetch in place). Throughput is one beat
// per clock while the key side takes beats. The six register stages are: window/offset
// subtract, multipliers, sums and rounding, compares and shifted coordinates, clamp and
// circle threshold reduction, then the output register. The circle threshold multiply
// a^2 * (W^2 + H^2) is cut into two partial products over stages four and five. Each
// stage loads whenever it is empty or its contents move on, so bubbles collapse. While a
// finished key beat waits, pix stays ready until stages one to five are full; pix_ready
// then drops until the key beat is taken. Config writes are registered; write them only
// while no beat is in flight. Frame size saturates at MAX_DIM and amount at one (65536).
// No clearing pass after reset.
module video_wipe_key_generator_unit #(
	parameter int MAX_DIM = vwkg_pkg::MAX_DIM_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_ready,
	input  vwkg_pkg::pix_in_t                   pix,
	output logic                                key_valid,
	input  logic                                key_ready,
	output vwkg_pkg::pix_out_t                  key,
	input  logic                                cfg_wr_en,
	input  logic [vwkg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vwkg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW     = vwkg_pkg::COORD_W;
	localparam int AW     = vwkg_pkg::AMT_W;
	localparam int FRAC   = vwkg_pkg::AMT_FRAC;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int SGN_W  = ((DIM_W > CW + 1) ? DIM_W : CW + 1) + 1;
	localparam int MAG_W  = SGN_W - 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int D2_W   = SQ_W + 1;
	localparam int PR_W   = DIM_W + AW;
	localparam int MX_W   = PR_W - FRAC;
	localparam int SH_W   = PR_W - FRAC - 1;
	localparam int RW     = ((MX_W > CW) ? MX_W : CW) + 1;
	localparam int EX_W   = MAG_W + FRAC;
	localparam int CMP_W  = (EX_W > PR_W) ? EX_W : PR_W;
	localparam int SX_W   = SGN_W + 2;
	localparam int LIM_W  = CW + 1;
	localparam int THR_W  = 2 * AW + 2 * DIM_W + 1 - vwkg_pkg::LHS_SHIFT;
	localparam int CC_W   = (D2_W > THR_W) ? D2_W : THR_W;

	// ---------------------------------------------------------------- config registers
	logic [vwkg_pkg::MODE_W-1:0]    mode_q;
	logic [vwkg_pkg::DIM_CFG_W-1:0] width_q, height_q;
	logic [AW-1:0]                  amount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= vwkg_pkg::MODE_RESET;
			width_q  <= vwkg_pkg::WIDTH_RESET;
			height_q <= vwkg_pkg::HEIGHT_RESET;
			amount_q <= vwkg_pkg::AMOUNT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				vwkg_pkg::REG_MODE:   mode_q   <= cfg_data[vwkg_pkg::MODE_W-1:0];
				vwkg_pkg::REG_WIDTH:  width_q  <= cfg_data[vwkg_pkg::DIM_CFG_W-1:0];
				vwkg_pkg::REG_HEIGHT: height_q <= cfg_data[vwkg_pkg::DIM_CFG_W-1:0];
				vwkg_pkg::REG_AMOUNT: amount_q <= cfg_data[AW-1:0];
				default: ;
			endcase
		end
	end

	// Saturated config; only the user keeps it stable while any beat is in flight.
	logic [DIM_W-1:0] w_sat, h_sat, half_w, half_h;
	logic [AW-1:0]    a_sat, bn;
	logic [LIM_W-1:0] lim_w, lim_h;

	assign w_sat  = (int'(width_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(width_q);
	assign h_sat  = (int'(height_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(height_q);
	assign half_w = w_sat >> 1;
	assign half_h = h_sat >> 1;
	assign a_sat  = (amount_q > vwkg_pkg::AMT_ONE) ? vwkg_pkg::AMT_ONE : amount_q;
	assign bn     = vwkg_pkg::AMT_ONE - a_sat;
	// fetch limit of the split wipe: min(size, 4096)
	assign lim_w  = (int'(w_sat) > vwkg_pkg::COORD_SPAN) ?
	                LIM_W'(vwkg_pkg::COORD_SPAN) : LIM_W'(w_sat);
	assign lim_h  = (int'(h_sat) > vwkg_pkg::COORD_SPAN) ?
	                LIM_W'(vwkg_pkg::COORD_SPAN) : LIM_W'(h_sat);

	// ---------------------------------------------------------------- stage control
	// A stage loads when it is empty or its contents move on; the output register
	// moves on when the key beat is taken.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	vwkg_pkg::stage_en_t thr_en;

	assign en_s6 = !v_s6 || key_ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign pix_ready = en_s1;
	assign key_valid = v_s6;

	assign thr_en.s2 = en_s2;
	assign thr_en.s3 = en_s3;
	assign thr_en.s4 = en_s4;
	assign thr_en.s5 = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Offsets from the frame centre and distances from the split cross.
	logic signed [SGN_W-1:0] dx_c, dy_c, ex_c, ey_c;
	logic signed [SGN_W-1:0] dx_s1, dy_s1;
	logic [MAG_W-1:0]        ex_abs_s1, ey_abs_s1;
	logic [CW-1:0]           x_s1, y_s1;
	logic                    x_gt_s1, y_gt_s1;

	assign dx_c = $signed(SGN_W'(pix.pixel_x)) - $signed(SGN_W'(half_w));
	assign dy_c = $signed(SGN_W'(pix.pixel_y)) - $signed(SGN_W'(half_h));
	assign ex_c = $signed(SGN_W'({pix.pixel_x, 1'b0})) - $signed(SGN_W'(w_sat));
	assign ey_c = $signed(SGN_W'({pix.pixel_y, 1'b0})) - $signed(SGN_W'(h_sat));

	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1      <= pix.pixel_x;
			y_s1      <= pix.pixel_y;
			dx_s1     <= dx_c;
			dy_s1     <= dy_c;
			ex_abs_s1 <= ex_c[SGN_W-1] ? MAG_W'(-ex_c) : MAG_W'(ex_c);
			ey_abs_s1 <= ey_c[SGN_W-1] ? MAG_W'(-ey_c) : MAG_W'(ey_c);
			// strictly right of / below the centre column / row
			x_gt_s1   <= !dx_c[SGN_W-1] && (dx_c != '0);
			y_gt_s1   <= !dy_c[SGN_W-1] && (dy_c != '0);
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Multipliers: squared offsets, box margins, split thresholds and shifts.
	logic signed [2*SGN_W-1:0] dxsq_c, dysq_c;
	logic [SQ_W-1:0]           dxsq_s2, dysq_s2;
	logic [PR_W-1:0]           pmx_s2, pmy_s2, aw_s2, ah_s2;
	logic [MAG_W-1:0]          ex_abs_s2, ey_abs_s2;
	logic [CW-1:0]             x_s2, y_s2;
	logic                      x_gt_s2, y_gt_s2;

	assign dxsq_c = dx_s1 * dx_s1;
	assign dysq_c = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			dxsq_s2   <= dxsq_c[SQ_W-1:0];
			dysq_s2   <= dysq_c[SQ_W-1:0];
			pmx_s2    <= PR_W'(half_w) * PR_W'(bn);
			pmy_s2    <= PR_W'(half_h) * PR_W'(bn);
			aw_s2     <= PR_W'(w_sat) * PR_W'(a_sat);
			ah_s2     <= PR_W'(h_sat) * PR_W'(a_sat);
			ex_abs_s2 <= ex_abs_s1;
			ey_abs_s2 <= ey_abs_s1;
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			x_gt_s2   <= x_gt_s1;
			y_gt_s2   <= y_gt_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// Round the box margins and split shifts; decide the split cross.
	logic [PR_W-1:0]  mx_sum, my_sum, shx_sum, shy_sum;
	logic             split_take_c;
	logic [D2_W-1:0]  d2_s3;
	logic [MX_W-1:0]  mx_s3, my_s3;
	logic [SH_W-1:0]  shx_s3, shy_s3;
	logic             split_take_s3;
	logic [CW-1:0]    x_s3, y_s3;
	logic             x_gt_s3, y_gt_s3;

	assign mx_sum  = pmx_s2 + PR_W'(1 << (FRAC - 1));
	assign my_sum  = pmy_s2 + PR_W'(1 << (FRAC - 1));
	assign shx_sum = aw_s2 + PR_W'(1 << FRAC);
	assign shy_sum = ah_s2 + PR_W'(1 << FRAC);

	assign split_take_c = (a_sat == vwkg_pkg::AMT_ONE) ||
	                      (CMP_W'({ey_abs_s2, {FRAC{1'b0}}}) < CMP_W'(ah_s2)) ||
	                      (CMP_W'({ex_abs_s2, {FRAC{1'b0}}}) < CMP_W'(aw_s2));

	always_ff @(posedge clk) begin
		if (en_s3) begin
			d2_s3         <= D2_W'(dxsq_s2) + D2_W'(dysq_s2);
			mx_s3         <= mx_sum[PR_W-1:FRAC];
			my_s3         <= my_sum[PR_W-1:FRAC];
			shx_s3        <= shx_sum[PR_W-1:FRAC+1];
			shy_s3        <= shy_sum[PR_W-1:FRAC+1];
			split_take_s3 <= split_take_c;
			x_s3          <= x_s2;
			y_s3          <= y_s2;
			x_gt_s3       <= x_gt_s2;
			y_gt_s3       <= y_gt_s2;
		end
	end

	// ---------------------------------------------------------------- stage 4
	// Box test (x >= W - mx written as x + mx >= W) and shifted fetch coordinates.
	logic                    rect_out_c;
	logic signed [SX_W-1:0]  xs_c, ys_c, shxs_c, shys_c;
	logic signed [SX_W-1:0]  sx_raw_s4, sy_raw_s4;
	logic                    rect_take_s4, split_take_s4;
	logic [D2_W-1:0]         d2_s4;
	logic [CW-1:0]           x_s4, y_s4;

	assign rect_out_c = (RW'(x_s3) < RW'(mx_s3)) ||
	                    (RW'(x_s3) + RW'(mx_s3) >= RW'(w_sat)) ||
	                    (RW'(y_s3) < RW'(my_s3)) ||
	                    (RW'(y_s3) + RW'(my_s3) >= RW'(h_sat));

	assign xs_c   = $signed(SX_W'(x_s3));
	assign ys_c   = $signed(SX_W'(y_s3));
	assign shxs_c = $signed(SX_W'(shx_s3));
	assign shys_c = $signed(SX_W'(shy_s3));

	always_ff @(posedge clk) begin
		if (en_s4) begin
			rect_take_s4  <= !rect_out_c;
			split_take_s4 <= split_take_s3;
			sx_raw_s4     <= x_gt_s3 ? (xs_c - shxs_c) : (xs_c + shxs_c);
			sy_raw_s4     <= y_gt_s3 ? (ys_c - shys_c) : (ys_c + shys_c);
			d2_s4         <= d2_s3;
			x_s4          <= x_s3;
			y_s4          <= y_s3;
		end
	end

	// ---------------------------------------------------------------- stage 5
	// Clamp the split fetch into the frame; the circle threshold lands here too.
	function automatic logic [CW-1:0] clamp_coord(input logic signed [SX_W-1:0] v,
	                                              input logic [LIM_W-1:0] lim);
		logic [LIM_W-1:0] top;
		logic [CW-1:0]    r;
		top = lim - LIM_W'(1);
		if (lim == '0 || v[SX_W-1]) begin
			r = '0;
		end else if (v >= $signed(SX_W'(lim))) begin
			r = top[CW-1:0];
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	logic [THR_W-1:0] thr_s5;
	logic [CW-1:0]    sx_s5, sy_s5, x_s5, y_s5;
	logic [D2_W-1:0]  d2_s5;
	logic             rect_take_s5, split_take_s5;

	vwkg_circle_thr #(
		.MAX_DIM (MAX_DIM)
	) u_circle_thr (
		.clk        (clk),
		.stage_en   (thr_en),
		.amount_sat (a_sat),
		.width_sat  (w_sat),
		.height_sat (h_sat),
		.thr        (thr_s5)
	);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			sx_s5         <= clamp_coord(sx_raw_s4, lim_w);
			sy_s5         <= clamp_coord(sy_raw_s4, lim_h);
			rect_take_s5  <= rect_take_s4;
			split_take_s5 <= split_take_s4;
			d2_s5         <= d2_s4;
			x_s5          <= x_s4;
			y_s5          <= y_s4;
		end
	end

	// ---------------------------------------------------------------- stage 6
	// Pick the wipe and hold the key beat until it is taken.
	// Circle: lhs = d2 << 34 exceeds rhs exactly when d2 exceeds rhs >> 34.
	vwkg_pkg::pix_out_t key_c;
	vwkg_pkg::pix_out_t key_s6;

	always_comb begin
		key_c.take_second = 1'b0;
		key_c.source_x    = x_s5;
		key_c.source_y    = y_s5;
		unique case (mode_q)
			vwkg_pkg::MODE_IRIS_RECT: begin
				key_c.take_second = rect_take_s5;
			end
			vwkg_pkg::MODE_IRIS_CIRCLE: begin
				key_c.take_second = CC_W'(d2_s5) <= CC_W'(thr_s5);
			end
			vwkg_pkg::MODE_SPLIT4: begin
				key_c.take_second = split_take_s5;
				if (!split_take_s5) begin
					key_c.source_x = sx_s5;
					key_c.source_y = sy_s5;
				end
			end
			default: begin
				// unused mode code: show the first source in place
				key_c.take_second = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			key_s6 <= key_c;
		end
	end

	assign key = key_s6;

endmodule

// ===== rtl/vwkg_checker.sv =====
// vwkg_checker.sv
// Port-level checker for the wipe key generator, bound to the top level.
// Depends on vwkg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vwkg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pix_valid,
	input logic               pix_ready,
	input logic               key_valid,
	input logic               key_ready,
	input vwkg_pkg::pix_out_t key
);

	// hold a stalled key beat
	`VWKG_ASSERT_NEXT(a_key_hold, clk, arst_n, key_valid && !key_ready, key_valid && $stable(key), "key beat changed while stalled")

	// an empty or draining output register never blocks the pixel side
	`VWKG_ASSERT_SAME(a_pix_ready, clk, arst_n, !key_valid || key_ready, pix_ready, "pix_ready low with output free")

	// with the output draining, an accepted pixel shows up on the key side once it has passed every pipeline stage
	`VWKG_ASSERT_NEXT(a_latency, clk, arst_n, (pix_valid && pix_ready) ##1 key_ready ##1 key_ready ##1 key_ready ##1 key_ready ##1 key_ready, key_valid, "key beat missing after pipeline latency")

endmodule

bind video_wipe_key_generator_unit vwkg_checker u_vwkg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.key_valid (key_valid),
	.key_ready (key_ready),
	.key       (key)
);

// ===== tb/sv/video_wipe_key_generator_unit_test.sv =====
// video_wipe_key_generator_unit_test.sv
// Self-checking testbench for the wipe key generator: directed wipes, corner cases, random phases.
// Depends on vwkg_pkg and video_wipe_key_generator_unit.
`timescale 1ns / 100ps

module video_wipe_key_generator_unit_test;
	import vwkg_pkg::*;

	// Frame size ceiling handed to the block; the key model saturates to the same value.
	localparam int FRAME_MAX = MAX_DIM_DEFAULT;
	localparam int CYCLE_LIMIT = 200000;
	// Idle clocks after the last key beat before the block counts as quiet.
	localparam int QUIET_CYCLES = 8;
	localparam int RANDOM_PHASES = 50;
	localparam int FULL_RATE_PHASES = 4;
	localparam int FULL_RATE_BEATS = 50;

	// Mode code that the block must treat as a pass-through.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// Fixed-point constants of the key arithmetic (amount is unsigned Q16).
	localparam longint Q_FRAC = AMT_FRAC;
	localparam longint Q_ONE = 1 << AMT_FRAC;
	localparam longint Q_HALF = 1 << (AMT_FRAC - 1);
	localparam longint CIRCLE_SHIFT = 2 * AMT_FRAC + 2;
	localparam longint COORD_LIMIT = 1 << COORD_W;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_ready;
	pix_in_t pix;
	logic key_valid;
	logic key_ready;
	pix_out_t key;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the wipe registers, kept in step with every write.
	logic [MODE_W-1:0] cur_mode;
	logic [DIM_CFG_W-1:0] cur_width;
	logic [DIM_CFG_W-1:0] cur_height;
	logic [AMT_W-1:0] cur_amount;

	// Keys predicted for accepted pixel beats, oldest first.
	pix_out_t key_pending[$];
	int mismatches;
	int cycle_count;
	// Random bubbles on the pixel side and stalls on the key side.
	bit idle_on;

	video_wipe_key_generator_unit #(
		.MAX_DIM(FRAME_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix(pix),
		.key_valid(key_valid),
		.key_ready(key_ready),
		.key(key),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Saturate a split fetch coordinate to the visible part of the frame.
	function automatic longint clamp_to_frame(input longint v, input longint dim);
		longint top;
		top = ((dim < COORD_LIMIT) ? dim : COORD_LIMIT) - 1;
		if (top < 0)
			return 0;
		if (v < 0)
			return 0;
		if (v > top)
			return top;
		return v;
	endfunction

	// Work out the key beat for one pixel coordinate under the current registers.
	// All terms stay below 2^60, so signed 64-bit arithmetic is exact.
	function automatic pix_out_t compute_key(input pix_in_t p);
		longint x, y, w, h, a;
		longint mx, my, dx, dy, ex, ey, shx, shy;
		longint sx, sy;
		logic take;
		pix_out_t r;
		x = p.pixel_x;
		y = p.pixel_y;
		w = (cur_width > FRAME_MAX) ? FRAME_MAX : cur_width;
		h = (cur_height > FRAME_MAX) ? FRAME_MAX : cur_height;
		a = (cur_amount > AMT_ONE) ? AMT_ONE : cur_amount;
		take = 1'b0;
		sx = x;
		sy = y;
		case (cur_mode)
			MODE_IRIS_RECT: begin
				// Border width shrinks with progress; the box inside it shows the second source.
				mx = ((w >> 1) * (Q_ONE - a) + Q_HALF) >> Q_FRAC;
				my = ((h >> 1) * (Q_ONE - a) + Q_HALF) >> Q_FRAC;
				take = !(x < mx || x >= w - mx || y < my || y >= h - my);
			end
			MODE_IRIS_CIRCLE: begin
				// Squared radius test against a^2 times the squared half-diagonal.
				dx = x - (w >> 1);
				dy = y - (h >> 1);
				take = !(((dx * dx + dy * dy) << CIRCLE_SHIFT) > a * a * (w * w + h * h));
			end
			MODE_SPLIT4: begin
				ey = magnitude(2 * y - h) * Q_ONE;
				ex = magnitude(2 * x - w) * Q_ONE;
				if (a >= Q_ONE || ey < a * h || ex < a * w) begin
					take = 1'b1;
				end else begin
					// Push each quadrant outward by half the amount of the frame size.
					shx = (w * a + Q_ONE) >> (Q_FRAC + 1);
					shy = (h * a + Q_ONE) >> (Q_FRAC + 1);
					sx = clamp_to_frame((x > (w >> 1)) ? x - shx : x + shx, w);
					sy = clamp_to_frame((y > (h >> 1)) ? y - shy : y + shy, h);
				end
			end
			default: begin
			end
		endcase
		r.take_second = take;
		r.source_x = sx[COORD_W-1:0];
		r.source_y = sy[COORD_W-1:0];
		return r;
	endfunction

	// Send one pixel beat; hold valid and payload until the block takes it.
	task automatic push_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		pix_in_t p;
		p.pixel_x = x;
		p.pixel_y = y;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		do
			@(posedge clk);
		while (!pix_ready);
		key_pending.push_back(compute_key(p));
	endtask

	// Drop valid and wait until every predicted key beat has come back, then let the block sit quiet.
	task automatic wait_for_keys();
		pix_valid <= 1'b0;
		while (key_pending.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Write all four wipe registers on consecutive clocks once the pipeline is empty.
	task automatic program_wipe(input logic [MODE_W-1:0] mode, input logic [DIM_CFG_W-1:0] w,
			input logic [DIM_CFG_W-1:0] h, input logic [AMT_W-1:0] amt);
		logic [CFG_IDX_W-1:0] regs [4];
		logic [CFG_DATA_W-1:0] vals [4];
		wait_for_keys();
		regs = '{REG_MODE, REG_WIDTH, REG_HEIGHT, REG_AMOUNT};
		vals = '{CFG_DATA_W'(mode), CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(amt)};
		cur_mode = mode;
		cur_width = w;
		cur_height = h;
		cur_amount = amt;
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [DIM_CFG_W-1:0] random_dim();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DIM_CFG_W'(1);
			2: return DIM_CFG_W'(FRAME_MAX);
			3: return DIM_CFG_W'($urandom);
			4: return DIM_CFG_W'($urandom_range(FRAME_MAX + 1, (1 << DIM_CFG_W) - 1));
			default: return DIM_CFG_W'($urandom_range(2, FRAME_MAX));
		endcase
	endfunction

	function automatic logic [AMT_W-1:0] random_amount();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return AMT_ONE;
			2: return '1;
			3: return AMT_W'($urandom);
			default: return AMT_W'($urandom_range(0, Q_ONE));
		endcase
	endfunction

	// Mostly coordinates inside the frame, sometimes anywhere in the 12-bit space.
	task automatic push_random_pixel();
		int wspan, hspan;
		wspan = (cur_width == 0) ? 1 : ((cur_width > COORD_LIMIT) ? COORD_LIMIT : cur_width);
		hspan = (cur_height == 0) ? 1 : ((cur_height > COORD_LIMIT) ? COORD_LIMIT : cur_height);
		if ($urandom_range(0, 3) == 0)
			push_pixel(COORD_W'($urandom), COORD_W'($urandom));
		else
			push_pixel(COORD_W'($urandom_range(0, wspan - 1)),
				COORD_W'($urandom_range(0, hspan - 1)));
	endtask

	// Registers at their reset values: rectangle iris at zero progress, 640x480.
	task automatic test_reset_defaults();
		push_pixel(12'd0, 12'd0);
		push_pixel(12'd320, 12'd240);
	endtask

	task automatic test_iris_rect();
		program_wipe(MODE_IRIS_RECT, 13'd640, 13'd480, 17'd32768);
		push_pixel(12'd320, 12'd240);
		push_pixel(12'd160, 12'd120);
		push_pixel(12'd159, 12'd120);
		push_pixel(12'd0, 12'd0);
	endtask

	task automatic test_iris_circle();
		program_wipe(MODE_IRIS_CIRCLE, 13'd640, 13'd480, AMT_ONE);
		push_pixel(12'd0, 12'd0);
		push_pixel(12'd320, 12'd240);
		// Zero radius: only the exact center passes.
		program_wipe(MODE_IRIS_CIRCLE, 13'd640, 13'd480, 17'd0);
		push_pixel(12'd320, 12'd240);
	endtask

	task automatic test_four_way_split();
		program_wipe(MODE_SPLIT4, 13'd640, 13'd480, 17'd16384);
		push_pixel(12'd0, 12'd0);
		push_pixel(12'd639, 12'd479);
		push_pixel(12'd320, 12'd240);
		push_pixel(12'd100, 12'd400);
		program_wipe(MODE_SPLIT4, 13'd640, 13'd480, AMT_ONE);
		push_pixel(12'd5, 12'd5);
	endtask

	task automatic test_corner_cases();
		// Amount above one saturates to fully transitioned.
		program_wipe(MODE_IRIS_RECT, 13'd640, 13'd480, '1);
		push_pixel(12'd0, 12'd0);
		// Frame larger than the ceiling saturates in both directions.
		program_wipe(MODE_IRIS_RECT, 13'd8191, 13'd5000, 17'd40000);
		push_pixel(12'd4095, 12'd4095);
		push_pixel(12'd0, 12'd0);
		// Zero frame size is used as written.
		program_wipe(MODE_SPLIT4, 13'd0, 13'd0, 17'd1000);
		push_pixel(12'd0, 12'd0);
		push_pixel(12'd4095, 12'd4095);
		// Unused mode code passes the coordinate through on the first source.
		program_wipe(MODE_UNUSED, 13'd640, 13'd480, 17'd30000);
		push_pixel(12'd4095, 12'd4095);
		// Pixel well outside a tiny frame.
		program_wipe(MODE_IRIS_CIRCLE, 13'd16, 13'd16, 17'd30000);
		push_pixel(12'd4095, 12'd0);
		// Split fetch pushed off the frame edge gets clamped.
		program_wipe(MODE_SPLIT4, 13'd4096, 13'd4096, 17'd60000);
		push_pixel(12'd4095, 12'd4095);
		push_pixel(12'd0, 12'd0);
		program_wipe(MODE_SPLIT4, 13'd1, 13'd1, 17'd20000);
		push_pixel(12'd0, 12'd0);
	endtask

	// Random settings per phase; now and then hold the sender until the pipeline is empty.
	task automatic test_random_phases();
		logic [MODE_W-1:0] mode;
		int beats;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			mode = MODE_W'($urandom_range(0, 2));
			if ($urandom_range(0, 11) == 0)
				mode = MODE_UNUSED;
			program_wipe(mode, random_dim(), random_dim(), random_amount());
			beats = $urandom_range(16, 42);
			for (int n = 0; n < beats; n++) begin
				if ((phase == 0 && n == beats / 2) || $urandom_range(0, 99) == 0)
					wait_for_keys();
				push_random_pixel();
			end
		end
	endtask

	// Closing stretch at one beat per clock with no bubbles or stalls.
	task automatic test_full_rate();
		idle_on = 1'b0;
		for (int phase = 0; phase < FULL_RATE_PHASES; phase++) begin
			program_wipe(MODE_W'($urandom_range(0, 2)), random_dim(), random_dim(),
				random_amount());
			for (int n = 0; n < FULL_RATE_BEATS; n++)
				push_random_pixel();
		end
	endtask

	// Key side: stall in short random bursts while idling is on.
	initial begin
		int hold;
		hold = 0;
		key_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold == 0 && idle_on && $urandom_range(0, 5) == 0)
				hold = $urandom_range(1, 6);
			key_ready <= (hold == 0);
			if (hold != 0)
				hold--;
		end
	end

	// Compare every accepted key beat with the oldest prediction, field by field.
	initial begin
		pix_out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && key_valid && key_ready) begin
				if (key_pending.size() == 0) begin
					$error("key beat with no pixel pending: %p", key);
					mismatches++;
				end else begin
					want = key_pending.pop_front();
					if (key.take_second !== want.take_second) begin
						$error("take_second: expected %0d, actual %0d", want.take_second,
							key.take_second);
						mismatches++;
					end
					if (key.source_x !== want.source_x) begin
						$error("source_x: expected %0d, actual %0d", want.source_x, key.source_x);
						mismatches++;
					end
					if (key.source_y !== want.source_y) begin
						$error("source_y: expected %0d, actual %0d", want.source_y, key.source_y);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog: end a hung run.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		mismatches = 0;
		idle_on = 1'b1;
		cur_mode = MODE_RESET;
		cur_width = WIDTH_RESET;
		cur_height = HEIGHT_RESET;
		cur_amount = AMOUNT_RESET;
		arst_n <= 1'b0;
		pix_valid <= 1'b0;
		pix <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		// Hold reset, then release it on a clock edge.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_iris_rect();
		test_iris_circle();
		test_four_way_split();
		test_corner_cases();
		test_random_phases();
		test_full_rate();

		// Drain the pipeline and let it sit quiet before judging.
		wait_for_keys();
		repeat (QUIET_CYCLES) @(posedge clk);
		if (mismatches == 0 && key_pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== video_wipe_key_generator_unit.f =====
+incdir+rtl
rtl/vwkg_pkg.sv
rtl/vwkg_circle_thr.sv
rtl/video_wipe_key_generator_unit.sv
rtl/vwkg_checker.sv
tb/sv/video_wipe_key_generator_unit_test.sv
